// File: rtl/core/tss_pkg.sv
// tss_pkg: shared types and constants for the timed setpoint scheduler.
// No dependencies; imported by tss_ram and timed_setpoint_scheduler.
package tss_pkg;

  localparam int TSS_DEPTH = 16;
  localparam int TIME_W    = 48;
  localparam int VAL_W     = 32;

  // one table entry as held in the RAM
  typedef struct packed {
    logic [TIME_W-1:0]       evt_time;
    logic signed [VAL_W-1:0] target;
  } tss_entry_t;

  // command codes
  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_ADVANCE = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  // configuration register indexes
  localparam logic REG_MIN_OUTPUT = 1'b0;
  localparam logic REG_MAX_OUTPUT = 1'b1;

  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [TIME_W-1:0]       TIME_NONE = {TIME_W{1'b1}};

endpackage

// File: rtl/core/timed_setpoint_scheduler.sv
// timed_setpoint_scheduler: time-sorted setpoint table with a clamped output.
// Depends on tss_pkg and tss_ram.
//
// Usage
//  Input channel (in_valid/in_stall) carries one command item: insert a
//  (time, target) setpoint, advance to a time, or clear the table. Each item
//  gives exactly one result item on the output channel (out_valid/out_stall):
//  the clamped output, earliest pending time (all ones when empty), the raw
//  front target, the entry count and the dropped flag.
//  Entries live in a circular buffer in one RAM (registered read). Insert walks
//  back from the tail, moving each later entry up one slot through a read
//  state and a compare-and-write state; advance pops each due entry from the
//  head through a read state and a compare state.
//  One item is in work at a time; in_stall is high from acceptance until the
//  result is loaded into the output register. The next item may be accepted
//  while that result still waits under out_stall; a second result then waits
//  in the pipe until the first is taken.
//  min_output/max_output are written through cfg_we/cfg_index/cfg_data; the user must write
//  them while idle, and the block itself does not enforce this. A write pulls the present
//  output inside the new bound. Reset (rst, synchronous) empties the table, zeroes the
//  output, forgets the last advance time and restores the widest clamp bounds. RAM is not cleared.
module timed_setpoint_scheduler
  import tss_pkg::*;
#(
  parameter int DEPTH = TSS_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  // command items
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     command,
  input  logic [TIME_W-1:0]              event_time,
  input  logic signed [VAL_W-1:0]        target_value,
  // result items
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [VAL_W-1:0]        output_value,
  output logic [TIME_W-1:0]              next_update_time,
  output logic signed [VAL_W-1:0]        front_target,
  output logic [$clog2(DEPTH+1)-1:0]     entry_count,
  output logic                           dropped,
  // configuration
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [VAL_W-1:0]               cfg_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_INS_HEAD, S_ADV_RD, S_ADV_CMP, S_FRONT, S_RESULT
  } state_t;

  state_t                  state;
  logic [IDX_W-1:0]        head;      // RAM slot of the earliest entry
  logic [CNT_W-1:0]        count;
  logic [IDX_W-1:0]        k;         // insert scan offset from head
  logic signed [VAL_W-1:0] cur_out;
  logic signed [VAL_W-1:0] min_out;
  logic signed [VAL_W-1:0] max_out;
  logic [TIME_W-1:0]       last_time;
  logic                    last_valid;
  logic [TIME_W-1:0]       time_q;
  logic signed [VAL_W-1:0] tgt_q;
  logic                    drop_q;

  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr;
  logic [IDX_W-1:0]        mem_raddr;
  tss_entry_t              mem_wdata;
  tss_entry_t              mem_rdata;

  // slot of (base + off) in the circular buffer, off < DEPTH
  function automatic logic [IDX_W-1:0] addr_of(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // above max wins over below min, so inverted bounds give max
  function automatic logic signed [VAL_W-1:0] clamp(input logic signed [VAL_W-1:0] v,
                                                    input logic signed [VAL_W-1:0] lo,
                                                    input logic signed [VAL_W-1:0] hi);
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  tss_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_stall = (state != S_IDLE);

  // RAM port control; the read port sits on head except during the insert scan
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = head;
    mem_raddr = head;
    mem_wdata = '{evt_time: time_q, target: tgt_q};
    case (state)
      S_INS_RD: begin
        mem_raddr = addr_of(head, CNT_W'(k));
      end
      S_INS_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = addr_of(head, CNT_W'(k) + CNT_W'(1));
        if (mem_rdata.evt_time > time_q) begin
          mem_wdata = mem_rdata;   // later entry moves up one slot
        end
      end
      S_INS_HEAD: begin
        mem_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      count      <= '0;
      k          <= '0;
      cur_out    <= '0;
      min_out    <= VAL_MIN;
      max_out    <= VAL_MAX;
      last_time  <= '0;
      last_valid <= 1'b0;
      drop_q     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // a result loaded this cycle sets valid below instead
      if (out_valid && !out_stall && state != S_RESULT) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          REG_MIN_OUTPUT: begin
            min_out <= $signed(cfg_data);
            if (cur_out < $signed(cfg_data)) cur_out <= $signed(cfg_data);
          end
          REG_MAX_OUTPUT: begin
            max_out <= $signed(cfg_data);
            if (cur_out > $signed(cfg_data)) cur_out <= $signed(cfg_data);
          end
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            time_q <= event_time;
            tgt_q  <= target_value;
            drop_q <= 1'b0;
            case (command)
              CMD_INSERT: begin
                if (count == CNT_W'(DEPTH)) begin
                  drop_q <= 1'b1;
                  state  <= S_FRONT;
                end else if (count == '0) begin
                  state <= S_INS_HEAD;
                end else begin
                  k     <= IDX_W'(count - CNT_W'(1));
                  state <= S_INS_RD;
                end
              end
              CMD_ADVANCE: begin
                if (last_valid && event_time == last_time) begin
                  state <= S_FRONT;
                end else begin
                  state <= S_ADV_RD;
                end
              end
              CMD_CLEAR: begin
                count <= '0;
                state <= S_FRONT;
              end
              default: state <= S_FRONT;
            endcase
          end
        end
        S_INS_RD: state <= S_INS_CMP;
        S_INS_CMP: begin
          if (mem_rdata.evt_time > time_q) begin
            if (k == '0) begin
              state <= S_INS_HEAD;
            end else begin
              k     <= k - IDX_W'(1);
              state <= S_INS_RD;
            end
          end else begin
            count <= count + CNT_W'(1);
            state <= S_FRONT;
          end
        end
        S_INS_HEAD: begin
          count <= count + CNT_W'(1);
          state <= S_FRONT;
        end
        S_ADV_RD: begin
          if (count == '0) begin
            last_time  <= time_q;
            last_valid <= 1'b1;
            state      <= S_FRONT;
          end else begin
            state <= S_ADV_CMP;
          end
        end
        S_ADV_CMP: begin
          if (mem_rdata.evt_time <= time_q) begin
            cur_out <= clamp(mem_rdata.target, min_out, max_out);
            head    <= addr_of(head, CNT_W'(1));
            count   <= count - CNT_W'(1);
            state   <= S_ADV_RD;
          end else begin
            last_time  <= time_q;
            last_valid <= 1'b1;
            state      <= S_FRONT;
          end
        end
        S_FRONT: state <= S_RESULT;   // head entry read in flight
        S_RESULT: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            output_value <= cur_out;
            entry_count  <= count;
            dropped      <= drop_q;
            if (count != '0) begin
              next_update_time <= mem_rdata.evt_time;
              front_target     <= mem_rdata.target;
            end else begin
              next_update_time <= TIME_NONE;
              front_target     <= cur_out;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // table never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // a dropped insert is only reported against a full table
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped |-> entry_count == CNT_W'(DEPTH))
    else $error("drop reported on a table with room");

  // empty table reports no next time and the output as front
  a_empty_front: assert property (@(posedge clk) disable iff (rst)
    out_valid && entry_count == '0 |->
      next_update_time == TIME_NONE && front_target == output_value)
    else $error("empty table result malformed");

  // RAM is written only by the insert sequence
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_INS_CMP || state == S_INS_HEAD))
    else $error("RAM write outside insert");

  // an accepted item always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state != S_IDLE)
    else $error("accepted item not taken into work");

endmodule

// File: rtl/core/tss_ram.sv
// tss_ram: simple dual-port entry RAM, one write and one registered read per cycle.
// Depends on tss_pkg for the entry type.
module tss_ram
  import tss_pkg::*;
#(
  parameter int DEPTH = TSS_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  tss_entry_t               wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output tss_entry_t               rdata
);

  tss_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: tb/timed_setpoint_scheduler_test.sv
// Self-checking bench for timed_setpoint_scheduler: directed setpoint cases, then
// random command traffic over several clamp settings, checked against a local model.
// Depends on tss_pkg and the timed_setpoint_scheduler RTL.
module timed_setpoint_scheduler_test;
  import tss_pkg::*;

  localparam int CNT_W = $clog2(TSS_DEPTH + 1);
  // command code that the block must treat as a no-op status request
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // cycles with nothing accepted on either channel before the run is abandoned
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int NUM_SETTINGS = 8;
  localparam int PHASE_ITEMS = 90;

  // one result item as seen on the output channel
  typedef struct {
    logic signed [VAL_W-1:0] out_val;
    logic [TIME_W-1:0]       next_time;
    logic signed [VAL_W-1:0] front;
    logic [CNT_W-1:0]        count;
    logic                    drop;
  } status_t;

  // Local copy of the setpoint table plus the queue of statuses still owed by
  // the block. Every accepted item yields exactly one status.
  class setpoint_scoreboard;
    logic [TIME_W-1:0]       slot_time [TSS_DEPTH];
    logic signed [VAL_W-1:0] slot_target [TSS_DEPTH];
    int unsigned             held;
    logic signed [VAL_W-1:0] setpoint;
    logic [TIME_W-1:0]       last_adv;
    bit                      adv_seen;
    logic signed [VAL_W-1:0] lo_bound;
    logic signed [VAL_W-1:0] hi_bound;
    status_t                 status_due[$];
    int unsigned             errors;
    int unsigned             checked;
    int unsigned             drops;

    function new();
      held = 0;
      setpoint = '0;
      last_adv = '0;
      adv_seen = 1'b0;
      lo_bound = VAL_MIN;
      hi_bound = VAL_MAX;
      errors = 0;
      checked = 0;
      drops = 0;
    endfunction

    function void write_reg(logic idx, logic [VAL_W-1:0] data);
      if (idx == REG_MIN_OUTPUT) begin
        lo_bound = data;
        if (setpoint < lo_bound) setpoint = lo_bound;
      end else begin
        hi_bound = data;
        if (setpoint > hi_bound) setpoint = hi_bound;
      end
    endfunction

    // upper bound is tested first, so inverted bounds favour max
    function logic signed [VAL_W-1:0] clamp_target(logic signed [VAL_W-1:0] v);
      if (v > hi_bound) return hi_bound;
      if (v < lo_bound) return lo_bound;
      return v;
    endfunction

    function void note_item(logic [1:0] cmd, logic [TIME_W-1:0] t,
                            logic signed [VAL_W-1:0] v);
      status_t     s;
      int unsigned pos;
      int unsigned popped;
      int unsigned i;
      s.drop = 1'b0;
      case (cmd)
        CMD_INSERT: begin
          if (held >= TSS_DEPTH) begin
            s.drop = 1'b1;
            drops++;
          end else begin
            pos = 0;
            // equal times land after the existing ones
            while (pos < held && slot_time[pos] <= t) pos++;
            for (i = held; i > pos; i--) begin
              slot_time[i] = slot_time[i-1];
              slot_target[i] = slot_target[i-1];
            end
            slot_time[pos] = t;
            slot_target[pos] = v;
            held++;
          end
        end
        CMD_ADVANCE: begin
          if (!(adv_seen && t == last_adv)) begin
            popped = 0;
            while (popped < held && slot_time[popped] <= t) begin
              setpoint = clamp_target(slot_target[popped]);
              popped++;
            end
            for (i = 0; i + popped < held; i++) begin
              slot_time[i] = slot_time[i+popped];
              slot_target[i] = slot_target[i+popped];
            end
            held -= popped;
            last_adv = t;
            adv_seen = 1'b1;
          end
        end
        CMD_CLEAR: held = 0;
        default: ;
      endcase
      s.out_val = setpoint;
      s.next_time = (held != 0) ? slot_time[0] : TIME_NONE;
      s.front = (held != 0) ? slot_target[0] : setpoint;
      s.count = CNT_W'(held);
      status_due.insert(status_due.size(), s);
    endfunction

    function void check_result(status_t got);
      status_t want;
      if (status_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected status item: out %h next %h front %h count %0d drop %b",
                   got.out_val, got.next_time, got.front, got.count, got.drop);
        return;
      end
      want = status_due[0];
      status_due.delete(0);
      checked++;
      if (got.out_val !== want.out_val || got.next_time !== want.next_time ||
          got.front !== want.front || got.count !== want.count ||
          got.drop !== want.drop) begin
        errors++;
        if (errors <= 10) begin
          $display("status mismatch at item %0d (exp/got): out %h/%h next %h/%h",
                   checked, want.out_val, got.out_val, want.next_time, got.next_time);
          $display("  front %h/%h count %0d/%0d drop %b/%b",
                   want.front, got.front, want.count, got.count, want.drop, got.drop);
        end
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              command = CMD_CLEAR;
  logic [TIME_W-1:0]       event_time = '0;
  logic signed [VAL_W-1:0] target_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [VAL_W-1:0] output_value;
  logic [TIME_W-1:0]       next_update_time;
  logic signed [VAL_W-1:0] front_target;
  logic [CNT_W-1:0]        entry_count;
  logic                    dropped;
  logic                    cfg_we = 1'b0;
  logic                    cfg_index = REG_MIN_OUTPUT;
  logic [VAL_W-1:0]        cfg_data = '0;

  setpoint_scoreboard sb;
  // idle rates in percent of cycles; both dropped to zero for one quiet phase
  int unsigned idle_pct = 28;
  int unsigned stall_pct = 28;
  int unsigned items_sent = 0;
  // main sets hold_go once; the receiver then counts out its own hold-off
  bit          hold_go = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  status_t     seen_status;

  timed_setpoint_scheduler u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .command          (command),
    .event_time       (event_time),
    .target_value     (target_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .output_value     (output_value),
    .next_update_time (next_update_time),
    .front_target     (front_target),
    .entry_count      (entry_count),
    .dropped          (dropped),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offer one command item, with random idle cycles ahead of it, and hold it
  // until accepted. Valid is only ever assigned once per edge: either lowered
  // for an idle cycle or raised with the new payload.
  task automatic send_item(input logic [1:0] cmd, input logic [TIME_W-1:0] t,
                           input logic signed [VAL_W-1:0] v);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    event_time <= t;
    target_value <= v;
    do @(posedge clk); while (in_stall);
    sb.note_item(cmd, t, v);
    items_sent++;
  endtask

  // Wait for every owed status, then a settling gap so the block is idle
  // before any register write.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.status_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_bounds(input logic signed [VAL_W-1:0] lo,
                              input logic signed [VAL_W-1:0] hi);
    cfg_we <= 1'b1;
    cfg_index <= REG_MIN_OUTPUT;
    cfg_data <= lo;
    @(posedge clk);
    sb.write_reg(REG_MIN_OUTPUT, lo);
    cfg_index <= REG_MAX_OUTPUT;
    cfg_data <= hi;
    @(posedge clk);
    sb.write_reg(REG_MAX_OUTPUT, hi);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [TIME_W-1:0] any_time();
    logic [TIME_W-1:0] t;
    t = {16'($urandom_range(0, 65535)), 32'($urandom)};
    // all ones lies outside the legal time range
    if (t == TIME_NONE) t = t - 1'b1;
    return t;
  endfunction

  // Random traffic around a moving time window so that inserts and advances
  // keep meeting: inserts land just ahead of "now", advances creep forward,
  // with some repeated advance times and some far-off noise times.
  task automatic run_phase(input int n, input int unsigned ins_pct);
    logic [TIME_W-1:0]       now;
    logic [TIME_W-1:0]       adv_t;
    logic [TIME_W-1:0]       t;
    logic [1:0]              c;
    logic signed [VAL_W-1:0] v;
    int unsigned             r;
    int unsigned             sub;
    now = {16'($urandom_range(0, 65534)), 32'($urandom)};
    adv_t = now;
    repeat (n) begin
      r = $urandom_range(0, 99);
      // half the targets are full range, half near the clamp settings (+/- 8.0)
      if ($urandom_range(0, 1) != 0) begin
        v = $urandom;
      end else begin
        v = $urandom_range(0, 32'h0010_0000);
        v = v - 32'sh0008_0000;
      end
      if (r < ins_pct) begin
        c = CMD_INSERT;
        t = now + $urandom_range(0, 200);
      end else if (r < ins_pct + 3) begin
        c = CMD_CLEAR;
        t = any_time();
      end else if (r < ins_pct + 5) begin
        c = CMD_UNUSED;
        t = any_time();
      end else begin
        c = CMD_ADVANCE;
        sub = $urandom_range(0, 99);
        if (sub < 10) begin
          t = adv_t;
        end else if (sub < 16) begin
          t = any_time();
        end else begin
          now = now + $urandom_range(1, 30);
          t = now;
        end
        adv_t = t;
      end
      send_item(c, t, v);
    end
  endtask

  // Receiver: checks each accepted status and drives out_stall, including the
  // one long hold-off that backs the block up into its input.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_status.out_val = output_value;
      seen_status.next_time = next_update_time;
      seen_status.front = front_target;
      seen_status.count = entry_count;
      seen_status.drop = dropped;
      sb.check_result(seen_status);
    end
    if (hold_go && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog: ends the run if neither channel moves an item for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : main
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
    int unsigned             k;
    logic [TIME_W-1:0]       t;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, at reset clamp bounds.
    // first advance on an empty table, then the same time again (no effect)
    send_item(CMD_ADVANCE, '0, 32'sh0001_0000);
    send_item(CMD_ADVANCE, '0, 32'sh0001_0000);
    send_item(CMD_UNUSED, TIME_NONE - 1'b1, VAL_MIN);
    // fill the table in falling time order so inserts shift later entries; times come
    // in threes so equal-time ordering shows, one entry at the latest time
    for (k = 0; k < TSS_DEPTH; k++) begin
      t = (k == 3) ? TIME_NONE - 1'b1 : TIME_W'(((TSS_DEPTH - 1 - k) / 3) * 100);
      send_item(CMD_INSERT, t,
                (k == 0) ? VAL_MAX : (k == 1) ? VAL_MIN : signed'($urandom));
    end
    // full table: refused
    send_item(CMD_INSERT, 48'd250, 32'sh0000_8000);
    // pops several, last popped wins; then a repeated time
    send_item(CMD_ADVANCE, 48'd250, '0);
    send_item(CMD_ADVANCE, 48'd250, '0);
    // pops the rest, including the entry at the latest time
    send_item(CMD_ADVANCE, TIME_NONE - 1'b1, '0);
    send_item(CMD_INSERT, 48'd7, 32'shFFFD_C000);
    // clear on a non-empty table leaves the output alone
    send_item(CMD_CLEAR, '0, '0);
    drain_results();

    // Random part over a range of clamp settings, extremes and inversions.
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      case (p)
        0: begin lo = VAL_MIN;        hi = VAL_MAX;        end
        1: begin lo = 32'shFFFB_0000; hi = 32'sh0005_0000; end
        2: begin lo = '0;             hi = '0;             end
        3: begin lo = VAL_MAX;        hi = VAL_MIN;        end
        4: begin lo = 32'sh0003_0000; hi = 32'shFFFD_0000; end
        5: begin lo = $urandom;       hi = $urandom;       end
        6: begin lo = VAL_MIN;        hi = '0;             end
        default: begin lo = 32'shFFFE_8000; hi = VAL_MAX; end
      endcase
      write_bounds(lo, hi);
      // one phase with no idling on either side
      idle_pct = (p == 2) ? 0 : 28;
      stall_pct = (p == 2) ? 0 : 28;
      run_phase(PHASE_ITEMS, (p % 3 == 0) ? 45 : (p % 3 == 1) ? 70 : 90);
      drain_results();
      // back-pressure: receiver holds off while the sender keeps offering
      if (p == 4) begin
        idle_pct = 0;
        hold_go = 1'b1;
        run_phase(40, 60);
        drain_results();
      end
    end

    $display("Covered %0d command items over %0d clamp settings plus reset bounds.",
             items_sent, NUM_SETTINGS);
    $display("%0d statuses checked, %0d inserts refused on a full table, %0d errors.",
             sb.checked, sb.drops, sb.errors);
    if (sb.errors == 0 && sb.status_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
